FILE: rtl/slpg_pkg.sv
// Status LED pattern generator: shared types, mode codes, register indexes
// and reset values. No dependencies.
`timescale 1ns / 1ps

package slpg_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int TIME_W      = 32;
  localparam int MODE_W      = 3;
  localparam int LEVEL_W     = 8;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BLINK_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PULSE_PERIOD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PULSE_STEP   = 2'd2;

  // Register reset values
  localparam logic [15:0]        BLINK_PERIOD_RST = 16'd250;
  localparam logic [15:0]        PULSE_PERIOD_RST = 16'd15;
  localparam logic [LEVEL_W-1:0] PULSE_STEP_RST   = 8'd4;

  // Commands
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_IDLE      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ESTOP     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BUSY      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ERROR     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NOT_HOMED = 3'd4;

  localparam logic [LEVEL_W-1:0] FULL = 8'd255;

  typedef struct packed {
    logic [15:0]        blink_period;
    logic [15:0]        pulse_period;
    logic [LEVEL_W-1:0] pulse_step;
  } slpg_cfg_t;

  typedef struct packed {
    logic              command;
    logic [TIME_W-1:0] now_ms;
    logic [MODE_W-1:0] new_mode;
  } slpg_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } slpg_color_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              shown_valid;
    slpg_color_t       shown_color;
  } slpg_status_t;

endpackage

FILE: rtl/slpg_if.sv
// Valid/ready channel interfaces for the status LED pattern generator:
// command items in, LED colors out. Depends on slpg_pkg.
`timescale 1ns / 1ps

interface slpg_in_if;
  import slpg_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [TIME_W-1:0] now_ms;
  logic [MODE_W-1:0] new_mode;

  modport source (output valid, command, now_ms, new_mode, input ready);
  modport sink   (input valid, command, now_ms, new_mode, output ready);
endinterface

interface slpg_out_if;
  import slpg_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] red;
  logic [LEVEL_W-1:0] green;
  logic [LEVEL_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

FILE: rtl/slpg_cfg_regs.sv
// Configuration registers: blink period, pulse period and pulse step,
// written through a plain write port. Depends on slpg_pkg.
`timescale 1ns / 1ps

module slpg_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             write_enable,
  input  logic [slpg_pkg::CFG_INDEX_W-1:0] write_index,
  input  logic [slpg_pkg::CFG_DATA_W-1:0]  write_data,
  output slpg_pkg::slpg_cfg_t              cfg
);
  import slpg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blink_period <= BLINK_PERIOD_RST;
      cfg.pulse_period <= PULSE_PERIOD_RST;
      cfg.pulse_step   <= PULSE_STEP_RST;
    end else if (write_enable) begin
      case (write_index)
        REG_BLINK_PERIOD: cfg.blink_period <= write_data;
        REG_PULSE_PERIOD: cfg.pulse_period <= write_data;
        REG_PULSE_STEP:   cfg.pulse_step   <= write_data[LEVEL_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

endmodule

FILE: rtl/slpg_engine.sv
// Pattern state and next-color logic: mode, blink phase, breathing ramp,
// step timestamp and the last shown color. Depends on slpg_pkg.
`timescale 1ns / 1ps

module slpg_engine (
  input  logic                   clk,
  input  logic                   rst,
  input  slpg_pkg::slpg_cfg_t    cfg,
  input  logic                   fire,
  input  slpg_pkg::slpg_item_t   item,
  output logic                   emit,
  output slpg_pkg::slpg_color_t  color,
  output slpg_pkg::slpg_status_t status
);
  import slpg_pkg::*;

  logic [MODE_W-1:0]  current_mode, current_mode_next;
  logic [TIME_W-1:0]  last_step_time, last_step_time_next;
  logic               blink_phase_on, blink_phase_on_next;
  logic [LEVEL_W-1:0] pulse_level, pulse_level_next;
  logic               pulse_rising, pulse_rising_next;
  slpg_color_t        shown_color;
  logic               shown_valid;

  logic [TIME_W-1:0]       elapsed;
  logic signed [LEVEL_W+1:0] ramp;
  logic                    have_color;

  assign elapsed = item.now_ms - last_step_time;

  always_comb begin
    if (pulse_rising) begin
      ramp = $signed({2'b00, pulse_level} + {2'b00, cfg.pulse_step});
    end else begin
      ramp = $signed({2'b00, pulse_level} - {2'b00, cfg.pulse_step});
    end
  end

  always_comb begin
    current_mode_next   = current_mode;
    last_step_time_next = last_step_time;
    blink_phase_on_next = blink_phase_on;
    pulse_level_next    = pulse_level;
    pulse_rising_next   = pulse_rising;
    have_color          = 1'b0;
    color               = '0;

    if (item.command == CMD_SET) begin
      if ((item.new_mode inside {[MODE_IDLE:MODE_NOT_HOMED]}) &&
          item.new_mode != current_mode) begin
        current_mode_next   = item.new_mode;
        blink_phase_on_next = 1'b1;
        pulse_level_next    = '0;
        pulse_rising_next   = 1'b1;
      end
    end else begin
      case (current_mode)
        MODE_IDLE: begin
          have_color  = 1'b1;
          color.green = FULL;
        end
        MODE_ESTOP: begin
          have_color = 1'b1;
          color.red  = FULL;
        end
        MODE_BUSY, MODE_ERROR: begin
          if (elapsed >= {16'd0, cfg.blink_period}) begin
            last_step_time_next = item.now_ms;
            blink_phase_on_next = !blink_phase_on;
            have_color          = 1'b1;
            if (current_mode == MODE_BUSY) begin
              color.green = blink_phase_on ? '0 : FULL;
            end else begin
              color.red = blink_phase_on ? '0 : FULL;
            end
          end
        end
        MODE_NOT_HOMED: begin
          if (elapsed >= {16'd0, cfg.pulse_period}) begin
            last_step_time_next = item.now_ms;
            have_color          = 1'b1;
            // clamp the ramp and turn it at either end
            if (ramp >= $signed({2'b00, FULL})) begin
              pulse_level_next  = FULL;
              pulse_rising_next = 1'b0;
            end else if (ramp <= $signed(10'sd0)) begin
              pulse_level_next  = '0;
              pulse_rising_next = 1'b1;
            end else begin
              pulse_level_next  = ramp[LEVEL_W-1:0];
            end
            color.blue = pulse_level_next;
          end
        end
        default: ;
      endcase
    end
  end

  assign emit = have_color && (!shown_valid || color != shown_color);

  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode   <= MODE_NOT_HOMED;
      last_step_time <= '0;
      blink_phase_on <= 1'b1;
      pulse_level    <= '0;
      pulse_rising   <= 1'b1;
      shown_color    <= '0;
      shown_valid    <= 1'b0;
    end else if (fire) begin
      current_mode   <= current_mode_next;
      last_step_time <= last_step_time_next;
      blink_phase_on <= blink_phase_on_next;
      pulse_level    <= pulse_level_next;
      pulse_rising   <= pulse_rising_next;
      if (emit) begin
        shown_color <= color;
        shown_valid <= 1'b1;
      end
    end
  end

  assign status.mode        = current_mode;
  assign status.shown_valid = shown_valid;
  assign status.shown_color = shown_color;

endmodule

FILE: rtl/status_led_pattern_generator_core.sv
// Status LED pattern generator top level: input register, pattern engine,
// result register and configuration registers. Depends on slpg_pkg, slpg_if.
//
//   channel   dir  payload                      transfer when
//   items     in   command, now_ms, new_mode    items.valid && items.ready
//   colors    out  red, green, blue             colors.valid && colors.ready
//   write_*   in   write_index, write_data      write_enable
//
// One item a cycle when no color stalls: an item waits in the input register,
// the engine updates its state as it moves on, and any new color lands in the
// result register at that edge, so a tick's color passes the input register and then the result register.
// Reset (rst, synchronous) empties both registers and restores the register
// defaults. A stalled color holds the result register and the item behind it;
// the input register still takes an item while it is empty.
`timescale 1ns / 1ps

module status_led_pattern_generator_core (
  input  logic                             clk,
  input  logic                             rst,
  slpg_in_if.sink                          items,
  slpg_out_if.source                       colors,
  input  logic                             write_enable,
  input  logic [slpg_pkg::CFG_INDEX_W-1:0] write_index,
  input  logic [slpg_pkg::CFG_DATA_W-1:0]  write_data
);
  import slpg_pkg::*;

  slpg_cfg_t    cfg;
  slpg_item_t   in_item;
  logic         in_valid;
  logic         slot_free;
  logic         fire;
  logic         emit;
  slpg_color_t  color;
  slpg_status_t status;
  logic         out_valid;
  slpg_color_t  out_color;

  slpg_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .cfg          (cfg)
  );

  assign slot_free    = !out_valid || colors.ready;
  assign fire         = in_valid && slot_free;
  assign items.ready  = !in_valid || slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (items.ready) begin
      in_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      in_item.command  <= items.command;
      in_item.now_ms   <= items.now_ms;
      in_item.new_mode <= items.new_mode;
    end
  end

  slpg_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .item   (in_item),
    .emit   (emit),
    .color  (color),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (colors.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_color <= color;
    end
  end

  assign colors.valid = out_valid;
  assign colors.red   = out_color.red;
  assign colors.green = out_color.green;
  assign colors.blue  = out_color.blue;

  // a set-mode item never yields a color
  a_set_no_color: assert property (@(posedge clk) disable iff (rst)
    (fire && in_item.command == CMD_SET) |=> !colors.valid)
    else $error("color after set-mode item");

  // the pending color is the one the engine records as shown
  a_out_is_shown: assert property (@(posedge clk) disable iff (rst)
    colors.valid |-> (status.shown_valid && out_color == status.shown_color))
    else $error("pending color differs from shown color");

  // an emitted color always differs from what was shown before
  a_emit_changes: assert property (@(posedge clk) disable iff (rst)
    (fire && emit && status.shown_valid) |-> color != status.shown_color)
    else $error("repeated color emitted");

  // the mode register never holds an undefined code
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    (fire && in_item.command == CMD_SET) |=> status.mode <= MODE_NOT_HOMED)
    else $error("undefined mode stored");

endmodule
